// ===== src/sta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet accumulator package
// Shared constants, request and response structs, and the cell control types.
// ----------------------------------------------------------------------------
package sta_pkg;

	localparam int DIM      = 64;
	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int GROUP    = 16;
	localparam int NGROUPS  = CAPACITY / GROUP;

	typedef enum logic [1:0] {
		REQ_ACC    = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_RANK   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_GATH,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         row_in;
		logic [5:0]         col_in;
		logic signed [31:0] value_in;
		logic [7:0]         rank_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [5:0]         row_out;
		logic [5:0]         col_out;
		logic               found;
		logic [8:0]         entry_count;
		logic               status;
	} rsp_t;

	typedef struct packed {
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] val;
	} entry_t;

	typedef struct packed {
		logic cmp_en;
		logic rank_mode;
		logic ins;
		logic acc_wr;
	} cell_ctrl_t;

endpackage

// ===== src/sta_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet accumulator cell
// Holds one sorted entry, compares it (or its index) with the broadcast key,
// takes its left neighbor's or the new entry on an insert, or a new sum.
// ----------------------------------------------------------------------------
module sta_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [sta_pkg::IDX_W-1:0] idx,
	input  logic [sta_pkg::CNT_W-1:0] count,
	input  sta_pkg::cell_ctrl_t   ctrl,
	input  logic [5:0]            key_row,
	input  logic [5:0]            key_col,
	input  logic [7:0]            rank,
	input  sta_pkg::entry_t       new_entry,
	input  logic signed [31:0]    sum,
	input  sta_pkg::entry_t       prev_entry,
	input  logic                  prev_less,
	output sta_pkg::entry_t       entry_q,
	output logic                  less_q,
	output logic                  sel_q
);
	import sta_pkg::*;

	logic occ;
	logic key_lt;
	logic key_eq;
	logic rank_eq;

	assign occ     = {1'b0, idx} < count;
	assign key_lt  = {entry_q.row, entry_q.col} < {key_row, key_col};
	assign key_eq  = {entry_q.row, entry_q.col} == {key_row, key_col};
	assign rank_eq = idx == IDX_W'(rank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_q <= 1'b0;
			sel_q  <= 1'b0;
		end else if (ctrl.cmp_en) begin
			less_q <= occ && key_lt;
			sel_q  <= occ && (ctrl.rank_mode ? rank_eq : key_eq);
		end
	end

	// Cells above the insert point take their neighbor's entry; the
	// cell exactly at the insert point takes the new entry.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (prev_less && !less_q) begin
				entry_q <= new_entry;
			end else if (!prev_less) begin
				entry_q <= prev_entry;
			end
		end else if (ctrl.acc_wr && sel_q) begin
			entry_q.val <= sum;
		end
	end

endmodule

// ===== src/sta_gather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet accumulator gather group
// Registers the OR of the selected entries of one group of cells.
// ----------------------------------------------------------------------------
module sta_gather (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sta_pkg::entry_t [sta_pkg::GROUP-1:0] entries,
	input  logic [sta_pkg::GROUP-1:0]    sel,
	output sta_pkg::entry_t              grp_q,
	output logic                         hit_q
);
	import sta_pkg::*;

	entry_t grp_d;

	always_comb begin
		grp_d = '0;
		for (int i = 0; i < GROUP; i++) begin
			grp_d = grp_d | (sel[i] ? entries[i] : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= |sel;
		end
	end

	always_ff @(posedge clk) begin
		grp_q <= grp_d;
	end

endmodule

// ===== src/sparse_triplet_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet accumulator
// Sorted coordinate-list store of a sparse matrix with accumulate, lookup,
// read by rank and clear, built as a row of entry cells.
// ----------------------------------------------------------------------------
// The done strobe follows the accepting edge through the compare, group
// gather, final reduce and update, and result register steps.
// A new transaction is taken only while idle; busy stays high from the
// accepting edge until the result is shown, and the receiver cannot stall.
// Reset clears the entry count and the control state; the entry cells are
// not cleared, and only entries below the count are ever read.
module sparse_triplet_accumulator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sta_pkg::req_t req,
	output logic          done,
	output sta_pkg::rsp_t rsp
);
	import sta_pkg::*;

	// Control and stored count.
	state_t             state_q;
	state_t             state_d;
	req_t               req_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	rsp_t               rsp_q;
	rsp_t               rsp_d;
	logic               done_q;
	cell_ctrl_t         ctrl;

	// Cell chain signals.
	entry_t [CAPACITY-1:0] cell_entry;
	logic   [CAPACITY-1:0] cell_less;
	logic   [CAPACITY-1:0] cell_sel;
	entry_t [NGROUPS-1:0]  grp_entry;
	logic   [NGROUPS-1:0]  grp_hit;

	// Final reduction of the group registers.
	entry_t             match;
	logic               hit;
	logic               in_range;
	logic               full;
	logic signed [31:0] sum;
	entry_t             new_entry;

	assign in_range = ({1'b0, req_q.row_in} < 7'(DIM)) && ({1'b0, req_q.col_in} < 7'(DIM));
	assign full     = count_q == CNT_W'(CAPACITY);
	assign sum      = match.val + req_q.value_in;

	assign new_entry.row = req_q.row_in;
	assign new_entry.col = req_q.col_in;
	assign new_entry.val = req_q.value_in;

	always_comb begin
		match = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			match = match | grp_entry[g];
		end
		hit = |grp_hit;
	end

	// Row of cells. Each cell sees its left neighbor's entry and its
	// less-than flag; cell zero sees a flag that is always set.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		logic   prev_l;
		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_l = 1'b1;
		end else begin : g_rest
			assign prev_e = cell_entry[i-1];
			assign prev_l = cell_less[i-1];
		end
		sta_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IDX_W'(i)),
			.count      (count_q),
			.ctrl       (ctrl),
			.key_row    (req_q.row_in),
			.key_col    (req_q.col_in),
			.rank       (req_q.rank_in),
			.new_entry  (new_entry),
			.sum        (sum),
			.prev_entry (prev_e),
			.prev_less  (prev_l),
			.entry_q    (cell_entry[i]),
			.less_q     (cell_less[i]),
			.sel_q      (cell_sel[i])
		);
	end

	// One gather register per group of cells; the selected cell is unique,
	// so an OR picks out its entry.
	for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
		sta_gather u_gather (
			.clk     (clk),
			.arst_n  (arst_n),
			.entries (cell_entry[g*GROUP +: GROUP]),
			.sel     (cell_sel[g*GROUP +: GROUP]),
			.grp_q   (grp_entry[g]),
			.hit_q   (grp_hit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
		if (state_q == S_FIN) begin
			rsp_q <= rsp_d;
		end
	end

	// Sequencer: next state, cell controls and the response of the final
	// cycle. Updates to the cells and the count land at the end of S_FIN.
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		rsp_d          = '0;
		ctrl           = '0;
		ctrl.rank_mode = (req_q.req_type == REQ_RANK);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctrl.cmp_en = 1'b1;
				state_d     = S_GATH;
			end
			S_GATH: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_IDLE;
				unique case (req_q.req_type)
					REQ_ACC: begin
						if (in_range) begin
							if (hit) begin
								ctrl.acc_wr     = 1'b1;
								rsp_d.value_out = sum;
								rsp_d.found     = 1'b1;
							end else if (full) begin
								rsp_d.status = 1'b1;
							end else begin
								ctrl.ins        = 1'b1;
								count_d         = count_q + 1'b1;
								rsp_d.value_out = req_q.value_in;
							end
						end
					end
					REQ_LOOKUP: begin
						if (in_range && hit) begin
							rsp_d.value_out = match.val;
							rsp_d.found     = 1'b1;
						end
					end
					REQ_RANK: begin
						if (hit) begin
							rsp_d.value_out = match.val;
							rsp_d.row_out   = match.row;
							rsp_d.col_out   = match.col;
							rsp_d.found     = 1'b1;
						end
					end
					REQ_CLEAR: begin
						count_d = '0;
					end
					default: begin
						count_d = count_q;
					end
				endcase
				rsp_d.entry_count = count_d;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// The count never passes the capacity of the cell row.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// A result is shown only right after the final update cycle.
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_FIN))
		else $error("done without a final cycle");

	// An accepted transaction enters the compare cycle next.
	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_CMP)
		else $error("accepted transaction did not start");

	// A dropped accumulate reports a full table and no match.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status |-> !rsp_q.found && rsp_q.entry_count == CNT_W'(CAPACITY))
		else $error("full status with inconsistent result");

endmodule
